### hdl/esm_pkg.sv
// ----------------------------------------------------------------------------
// esm_pkg: shared types and constants of the event signature matcher
// Item layouts, action and event-kind codes, and the fixed match strings.
// ----------------------------------------------------------------------------
package esm_pkg;

  // Window depths and the path length counter.
  localparam int unsigned PathDepth = 21;
  localparam int unsigned CmdDepth  = 9;
  localparam int unsigned LenWidth  = 5;
  localparam int unsigned NumPfx    = 4;
  localparam int unsigned NumCmdPat = 8;
  localparam int unsigned NumRules  = 7;
  localparam int unsigned PfxMax    = 20;

  // Action codes of an input item.
  typedef enum logic [1:0] {
    ActPath = 2'd0,
    ActCmd  = 2'd1,
    ActEnd  = 2'd2,
    ActNone = 2'd3
  } action_e;

  // Event kinds that the rules look at.
  localparam logic [2:0] KindProcStart = 3'd1;
  localparam logic [2:0] KindCreated   = 3'd2;
  localparam logic [2:0] KindModified  = 3'd3;
  localparam logic [2:0] KindMoved     = 3'd4;

  // Execute bits of the file mode (owner, group, other).
  localparam logic [11:0] ExecMask = 12'o0111;

  // Severity codes.
  localparam logic [1:0] SevNone     = 2'd0;
  localparam logic [1:0] SevMedium   = 2'd1;
  localparam logic [1:0] SevHigh     = 2'd2;
  localparam logic [1:0] SevCritical = 2'd3;

  // Windows hold the newest byte in element 0.
  typedef logic [PathDepth-1:0][7:0] path_win_t;
  typedef logic [CmdDepth-1:0][7:0]  cmd_win_t;
  typedef logic [PfxMax-1:0][7:0]    pfx_text_t;

  // Prefixes, right-justified: character p of a prefix of length n sits in
  // byte n-1-p. Bit 0 /tmp/, bit 1 /var/tmp/, bit 2 /dev/shm/, bit 3 systemd.
  localparam pfx_text_t PfxText [NumPfx] = '{
    160'("/tmp/"),
    160'("/var/tmp/"),
    160'("/dev/shm/"),
    160'("/etc/systemd/system/")
  };
  localparam logic [LenWidth-1:0] PfxLen [NumPfx] = '{5'd5, 5'd9, 5'd9, 5'd20};

  // Suffix that marks an authorized keys file; it fills the whole window.
  localparam path_win_t KeysText = 168'({"/.ssh/authorized", "_keys"});

  // Command substrings, right-justified so the last character is the newest.
  localparam cmd_win_t CmdPat [NumCmdPat] = '{
    72'("curl "),
    72'("wget "),
    72'("| sh"),
    72'("| bash"),
    72'("/dev/tcp/"),
    72'("base64"),
    72'(" -d"),
    72'("--decode")
  };
  localparam cmd_win_t CmdMask [NumCmdPat] = '{
    {{4{8'h00}}, {5{8'hff}}},
    {{4{8'h00}}, {5{8'hff}}},
    {{5{8'h00}}, {4{8'hff}}},
    {{3{8'h00}}, {6{8'hff}}},
    {9{8'hff}},
    {{3{8'h00}}, {6{8'hff}}},
    {{6{8'h00}}, {3{8'hff}}},
    {{1{8'h00}}, {8{8'hff}}}
  };

  // One input item.
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  char_byte;
    logic [2:0]  event_kind;
    logic [11:0] permission_bits;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [NumRules-1:0] rule_mask;
    logic [2:0]          fired_count;
    logic [1:0]          top_severity;
  } out_item_t;

  // Expected character of prefix sel at path position pos (pos below length).
  function automatic logic [7:0] pfx_char(input logic [1:0] sel,
                                          input logic [LenWidth-1:0] pos);
    logic [LenWidth-1:0] idx;
    idx = PfxLen[sel] - 5'd1 - pos;
    return PfxText[sel][idx];
  endfunction

endpackage

### hdl/esm_if.sv
// ----------------------------------------------------------------------------
// esm_in_if / esm_out_if: valid-ready channels of the event signature matcher
// One request moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface esm_in_if;
  import esm_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface esm_out_if;
  import esm_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/event_signature_matcher.sv
// ----------------------------------------------------------------------------
// event_signature_matcher: streaming rule matcher for process and file events
// Scans path and command bytes and reports fired rules at end of event.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle: a path byte, a command byte or
// an end-of-event request. Each request is held in an input register,
// where the prefix, suffix and substring logic updates the matcher state; an
// end-of-event request loads the result register as it leaves the input
// register, and the state is cleared for the next event. The input side
// stalls only when an end-of-event request reaches the input register while
// the previous result is still waiting in the result register.
module event_signature_matcher
  import esm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  esm_in_if.sink       in_i,
  esm_out_if.source    out_o
);

  // Input stage.
  logic     stage_valid_q;
  in_item_t stage_q;
  logic     stage_is_end;
  logic     stage_adv;
  logic     out_free;

  // Matcher state.
  path_win_t           path_tail_q, path_tail_d;
  cmd_win_t            cmd_tail_q, cmd_tail_d;
  logic [LenWidth-1:0] path_len_q, path_len_d;
  logic [NumPfx-1:0]   pfx_alive_q, pfx_alive_d;
  logic [NumCmdPat-1:0] cmd_seen_q, cmd_seen_d;

  // Result register.
  logic      out_valid_q;
  out_item_t out_q, out_d;

  // Handshake: the stage drains unless an end request meets a full result.
  assign stage_is_end = (stage_q.action == ActEnd);
  assign out_free     = !out_valid_q || out_o.ready;
  assign stage_adv    = stage_valid_q && (!stage_is_end || out_free);
  assign in_i.ready   = !stage_valid_q || stage_adv;
  assign out_o.valid  = out_valid_q;
  assign out_o.data   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      stage_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      stage_q <= in_i.data;
    end
  end

  // State update and rule evaluation for the request in the stage.
  always_comb begin
    logic temp_hit;
    logic sysd_hit;
    logic keys_hit;
    logic is_proc;
    logic is_file;
    logic [NumRules-1:0] fire;
    logic [2:0] cnt;
    logic [1:0] sev;

    path_tail_d = path_tail_q;
    cmd_tail_d  = cmd_tail_q;
    path_len_d  = path_len_q;
    pfx_alive_d = pfx_alive_q;
    cmd_seen_d  = cmd_seen_q;

    // Path state at end of event.
    temp_hit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      temp_hit = temp_hit || (pfx_alive_q[i] && (path_len_q >= PfxLen[i]));
    end
    sysd_hit = pfx_alive_q[3] && (path_len_q >= PfxLen[3]);
    keys_hit = (path_len_q >= LenWidth'(PathDepth)) && (path_tail_q == KeysText);

    is_proc = (stage_q.event_kind == KindProcStart);
    is_file = (stage_q.event_kind == KindCreated) ||
              (stage_q.event_kind == KindModified) ||
              (stage_q.event_kind == KindMoved);

    fire[0] = is_proc && temp_hit;
    fire[1] = is_proc && (|cmd_seen_q[1:0]) && (|cmd_seen_q[3:2]);
    fire[2] = is_proc && cmd_seen_q[4];
    fire[3] = is_proc && cmd_seen_q[5] && (|cmd_seen_q[7:6]);
    fire[4] = is_file && sysd_hit;
    fire[5] = is_file && keys_hit;
    fire[6] = is_file && temp_hit && ((stage_q.permission_bits & ExecMask) != '0);

    cnt = '0;
    for (int i = 0; i < NumRules; i++) begin
      cnt = cnt + {2'b00, fire[i]};
    end

    // Highest severity among the fired rules.
    if (fire[1]) begin
      sev = SevCritical;
    end else if (fire[0] || fire[2] || fire[4] || fire[5] || fire[6]) begin
      sev = SevHigh;
    end else if (fire[3]) begin
      sev = SevMedium;
    end else begin
      sev = SevNone;
    end

    out_d.rule_mask    = fire;
    out_d.fired_count  = cnt;
    out_d.top_severity = sev;

    case (action_e'(stage_q.action))
      ActPath: begin
        // Drop each prefix whose character at this position differs.
        for (int i = 0; i < NumPfx; i++) begin
          if ((path_len_q < PfxLen[i]) &&
              (stage_q.char_byte != pfx_char(2'(i), path_len_q))) begin
            pfx_alive_d[i] = 1'b0;
          end
        end
        if (path_len_q != '1) begin
          path_len_d = path_len_q + 5'd1;
        end
        path_tail_d = {path_tail_q[PathDepth-2:0], stage_q.char_byte};
      end
      ActCmd: begin
        // Shift the command window and set sticky substring flags.
        cmd_tail_d = {cmd_tail_q[CmdDepth-2:0], stage_q.char_byte};
        for (int i = 0; i < NumCmdPat; i++) begin
          if (((cmd_tail_d ^ CmdPat[i]) & CmdMask[i]) == '0) begin
            cmd_seen_d[i] = 1'b1;
          end
        end
      end
      ActEnd: begin
        // Clear everything for the next event.
        path_tail_d = '0;
        cmd_tail_d  = '0;
        path_len_d  = '0;
        pfx_alive_d = '1;
        cmd_seen_d  = '0;
      end
      default: begin
      end
    endcase
  end

  // Matcher state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_tail_q <= '0;
      cmd_tail_q  <= '0;
      path_len_q  <= '0;
      pfx_alive_q <= '1;
      cmd_seen_q  <= '0;
    end else if (stage_adv) begin
      path_tail_q <= path_tail_d;
      cmd_tail_q  <= cmd_tail_d;
      path_len_q  <= path_len_d;
      pfx_alive_q <= pfx_alive_d;
      cmd_seen_q  <= cmd_seen_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_adv && stage_is_end) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_adv && stage_is_end) begin
      out_q <= out_d;
    end
  end

  // An end request that leaves the stage always produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_adv && stage_is_end |=> out_valid_q)
    else $error("End of event did not load a result.");

  // State is back at its reset value after an end request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_adv && stage_is_end |=> (path_len_q == '0) && (cmd_seen_q == '0) &&
                                  (pfx_alive_q == '1))
    else $error("Matcher state not cleared after end of event.");

  // The count and severity agree with the mask.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (32'(out_q.fired_count) == $countones(out_q.rule_mask)) &&
                    ((out_q.rule_mask == '0) == (out_q.top_severity == SevNone)))
    else $error("Result fields disagree with the rule mask.");

endmodule

### tb/event_signature_matcher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// event_signature_matcher_tb: self-checking testbench of the signature matcher
// Streams path and command bytes of random and hand-made events through the
// request channel, predicts each verdict in the testbench and compares every
// returned verdict field by field, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module event_signature_matcher_tb;
  import esm_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned StimTarget = 1950;

  // Event kinds that no rule looks at.
  localparam logic [2:0] KindUnknown = 3'd0;
  localparam logic [2:0] KindOther   = 3'd7;

  // Pattern indexes used by the hand-made events.
  localparam int PfxTmp      = 0;
  localparam int PatShortOpt = 6;

  // Severity of each rule, rule 1 first.
  localparam logic [1:0] RuleSev [NumRules] = '{
    SevHigh, SevCritical, SevHigh, SevMedium, SevHigh, SevHigh, SevHigh
  };

  localparam string KeysSuffix = {"/.ssh/authorized", "_keys"};
  // Characters that often form near matches of the command substrings.
  localparam string CharMix = " -|/abcdehlorstuw64";

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  esm_in_if  in_if ();
  esm_out_if out_if ();

  event_signature_matcher i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Requests still to be sent and verdicts still to come back.
  in_item_t  request_q [$];
  out_item_t verdict_q [$];

  // Text of the event under construction.
  logic [7:0] path_buf [$];
  logic [7:0] cmd_buf [$];

  // Predicted matcher state; windows keep the newest byte last.
  logic [7:0]          path_win [PathDepth];
  logic [7:0]          cmd_win [CmdDepth];
  logic [LenWidth-1:0] path_cnt;
  logic [NumPfx-1:0]   pfx_live;
  logic [NumCmdPat-1:0] cmd_flags;

  bit              idling = 1'b1;
  bit              in_fire = 1'b0;
  int              gap_left = 0;
  int              stall_left = 0;
  int              errors = 0;
  int              stim_count = 0;
  int              end_count = 0;
  int              noise_count = 0;
  int              checked = 0;
  int unsigned     cycles = 0;
  logic [NumRules-1:0] rules_seen = '0;

  function automatic string prefix_text(input int k);
    case (k)
      0:       return "/tmp/";
      1:       return "/var/tmp/";
      2:       return "/dev/shm/";
      default: return "/etc/systemd/system/";
    endcase
  endfunction

  function automatic string cmd_text(input int k);
    case (k)
      0:       return "curl ";
      1:       return "wget ";
      2:       return "| sh";
      3:       return "| bash";
      4:       return "/dev/tcp/";
      5:       return "base64";
      6:       return " -d";
      default: return "--decode";
    endcase
  endfunction

  task automatic clear_matcher();
    int i;
    for (i = 0; i < PathDepth; i++) path_win[i] = 8'h00;
    for (i = 0; i < CmdDepth; i++) cmd_win[i] = 8'h00;
    path_cnt  = '0;
    pfx_live  = '1;
    cmd_flags = '0;
  endtask

  function automatic bit cmd_ends_with(input string pat);
    int i;
    for (i = 0; i < pat.len(); i++) begin
      if (cmd_win[CmdDepth - pat.len() + i] != pat[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // A prefix counts once the whole of it has been seen without a miss.
  function automatic bit prefix_hit(input int k);
    string s;
    s = prefix_text(k);
    return pfx_live[k] && path_cnt >= s.len();
  endfunction

  // Advances the predicted state by one accepted request; an end of event
  // queues the verdict it must produce.
  task automatic track_request(input in_item_t req);
    int                  k;
    int                  i;
    string               s;
    bit                  proc;
    bit                  file_ev;
    bit                  temp;
    bit                  keys;
    logic [NumRules-1:0] fire;
    out_item_t           res;
    case (req.action)
      ActPath: begin
        for (k = 0; k < NumPfx; k++) begin
          s = prefix_text(k);
          if (path_cnt < s.len() && req.char_byte != s[path_cnt]) pfx_live[k] = 1'b0;
        end
        if (path_cnt != '1) path_cnt = path_cnt + 1'b1;
        for (i = 0; i < PathDepth - 1; i++) path_win[i] = path_win[i+1];
        path_win[PathDepth-1] = req.char_byte;
      end
      ActCmd: begin
        for (i = 0; i < CmdDepth - 1; i++) cmd_win[i] = cmd_win[i+1];
        cmd_win[CmdDepth-1] = req.char_byte;
        for (k = 0; k < NumCmdPat; k++) begin
          if (cmd_ends_with(cmd_text(k))) cmd_flags[k] = 1'b1;
        end
      end
      ActEnd: begin
        proc    = req.event_kind == KindProcStart;
        file_ev = req.event_kind == KindCreated || req.event_kind == KindModified ||
                  req.event_kind == KindMoved;
        temp    = prefix_hit(0) || prefix_hit(1) || prefix_hit(2);
        keys    = path_cnt >= PathDepth;
        for (i = 0; i < PathDepth; i++) begin
          if (path_win[i] != KeysSuffix[i]) keys = 1'b0;
        end
        fire[0] = proc && temp;
        fire[1] = proc && (|cmd_flags[1:0]) && (|cmd_flags[3:2]);
        fire[2] = proc && cmd_flags[4];
        fire[3] = proc && cmd_flags[5] && (|cmd_flags[7:6]);
        fire[4] = file_ev && prefix_hit(3);
        fire[5] = file_ev && keys;
        fire[6] = file_ev && temp && (|(req.permission_bits & ExecMask));
        res = '0;
        res.rule_mask = fire;
        for (i = 0; i < NumRules; i++) begin
          if (fire[i]) begin
            res.fired_count = res.fired_count + 1'b1;
            if (RuleSev[i] > res.top_severity) res.top_severity = RuleSev[i];
          end
        end
        verdict_q.push_back(res);
        clear_matcher();
      end
      default: ;
    endcase
  endtask

  task automatic check_verdict(input out_item_t got);
    out_item_t want;
    checked++;
    if (verdict_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected verdict, expected none, got mask %h count %0d severity %0d",
               $time, got.rule_mask, got.fired_count, got.top_severity);
      return;
    end
    want = verdict_q.pop_front();
    rules_seen |= want.rule_mask;
    if (got.rule_mask !== want.rule_mask) begin
      errors++;
      $display("%0t: rule_mask expected %h, got %h", $time, want.rule_mask, got.rule_mask);
    end
    if (got.fired_count !== want.fired_count) begin
      errors++;
      $display("%0t: fired_count expected %0d, got %0d", $time, want.fired_count,
               got.fired_count);
    end
    if (got.top_severity !== want.top_severity) begin
      errors++;
      $display("%0t: top_severity expected %0d, got %0d", $time, want.top_severity,
               got.top_severity);
    end
  endtask

  function automatic in_item_t make_req(input logic [1:0] act, input logic [7:0] ch,
                                        input logic [2:0] kind, input logic [11:0] mode);
    in_item_t r;
    r.action          = act;
    r.char_byte       = ch;
    r.event_kind      = kind;
    r.permission_bits = mode;
    return r;
  endfunction

  task automatic add_text(input bit to_cmd, input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      if (to_cmd) cmd_buf.push_back(s[i]);
      else path_buf.push_back(s[i]);
    end
  endtask

  task automatic add_noise(input bit to_cmd, input int n, input bit any_byte);
    int         i;
    logic [7:0] ch;
    for (i = 0; i < n; i++) begin
      ch = any_byte ? 8'($urandom_range(0, 255)) : CharMix[$urandom_range(0, CharMix.len() - 1)];
      if (to_cmd) cmd_buf.push_back(ch);
      else path_buf.push_back(ch);
    end
  endtask

  // Interleaves the buffered path and command text at random, sprinkles in a
  // few ignored requests and closes the event.
  task automatic push_event(input logic [2:0] kind, input logic [11:0] mode);
    bit take_path;
    while (path_buf.size() != 0 || cmd_buf.size() != 0) begin
      if ($urandom_range(0, 24) == 0) begin
        request_q.push_back(make_req(ActNone, 8'($urandom), 3'($urandom), 12'($urandom)));
        noise_count++;
      end
      take_path = cmd_buf.size() == 0 || (path_buf.size() != 0 && $urandom_range(0, 1) == 1);
      if (take_path) begin
        request_q.push_back(make_req(ActPath, path_buf.pop_front(), 3'($urandom),
                                     12'($urandom)));
      end else begin
        request_q.push_back(make_req(ActCmd, cmd_buf.pop_front(), 3'($urandom),
                                     12'($urandom)));
      end
      stim_count++;
    end
    request_q.push_back(make_req(ActEnd, 8'($urandom), kind, mode));
    stim_count++;
    end_count++;
  endtask

  // Builds one event aimed at the rules: real prefixes and suffixes, near
  // misses, saturating paths and commands made of substring fragments.
  task automatic build_random_event();
    string       s;
    int          pos;
    logic [2:0]  kind;
    logic [11:0] mode;
    case ($urandom_range(0, 12))
      0, 1, 2, 3: begin
        add_text(0, prefix_text($urandom_range(0, 2)));
        add_noise(0, $urandom_range(0, 14), 0);
      end
      4: begin
        add_text(0, prefix_text(3));
        add_noise(0, $urandom_range(0, 14), 0);
      end
      5: begin
        add_noise(0, $urandom_range(0, 12), 0);
        add_text(0, KeysSuffix);
      end
      6: add_text(0, KeysSuffix.substr(1, KeysSuffix.len() - 1));
      7: begin
        // A prefix with one character swapped.
        s   = prefix_text($urandom_range(0, 3));
        pos = $urandom_range(0, s.len() - 1);
        s.putc(pos, CharMix[$urandom_range(0, CharMix.len() - 1)]);
        add_text(0, s);
        add_noise(0, $urandom_range(0, 6), 0);
      end
      8: begin
        s = prefix_text($urandom_range(0, 3));
        add_text(0, s.substr(0, s.len() - 2));
      end
      9: add_noise(0, $urandom_range(0, 40), 1);
      10: begin
        add_text(0, prefix_text($urandom_range(0, 3)));
        add_noise(0, $urandom_range(0, 8), 0);
        add_text(0, KeysSuffix);
      end
      default: ;
    endcase
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: add_text(1, cmd_text($urandom_range(0, 7)));
        5: begin
          s = cmd_text($urandom_range(0, 7));
          add_text(1, s.substr(0, s.len() - 2));
        end
        6, 7, 8: add_noise(1, $urandom_range(1, 5), 0);
        default: add_noise(1, $urandom_range(1, 5), 1);
      endcase
    end
    case ($urandom_range(0, 5))
      0:       kind = 3'($urandom_range(0, 7));
      1, 2:    kind = KindProcStart;
      default: kind = 3'($urandom_range(KindCreated, KindMoved));
    endcase
    mode = 12'($urandom_range(0, 4095));
    if ($urandom_range(0, 2) == 0) mode &= ~ExecMask;
    push_event(kind, mode);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (request_q.size() != 0 || in_if.valid || verdict_q.size() != 0);
  endtask

  // Request driver: holds a request until taken, otherwise idles in bursts.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && !in_fire) begin
        // Request still waiting for the block.
      end else if (idling && gap_left != 0) begin
        in_if.valid <= 1'b0;
        gap_left--;
      end else if (request_q.size() != 0 && idling && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 15);
        in_if.valid <= 1'b0;
      end else if (request_q.size() != 0) begin
        in_if.valid <= 1'b1;
        in_if.data  <= request_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure in bursts.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (idling && stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: tracks accepted requests and checks returned verdicts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_fire <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) track_request(in_if.data);
      if (out_if.valid && out_if.ready) check_verdict(out_if.data);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("event_signature_matcher_tb failed");
      $finish;
    end
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    clear_matcher();

    // Empty event on a process start.
    push_event(KindProcStart, 12'o0000);
    // Unused action code with every field bit set.
    request_q.push_back(make_req(ActNone, 8'hff, 3'h7, 12'hfff));
    noise_count++;
    // Temp directory path on a process start.
    add_text(0, prefix_text(PfxTmp));
    push_event(KindProcStart, 12'hfff);
    // Zero and all-ones bytes are plain data; the kind matches no rule.
    path_buf.push_back(8'h00);
    cmd_buf.push_back(8'h00);
    path_buf.push_back(8'hff);
    push_event(KindOther, 12'hfff);
    add_text(1, cmd_text(PatShortOpt));
    push_event(KindUnknown, 12'hfff);
    // Temp directory file with only the other-execute bit set.
    add_text(0, prefix_text(PfxTmp));
    push_event(KindCreated, 12'o0001);

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Hold the sender until every verdict so far is back.
    wait_drained();
    while (stim_count < 900) build_random_event();
    wait_drained();

    // Alternate stretches with and without idling, one event at a time.
    while (stim_count < StimTarget - 300) begin
      idling = $urandom_range(0, 2) != 0;
      build_random_event();
      while (request_q.size() != 0) @(posedge clk_i);
    end
    wait_drained();

    // Closing stretch at full rate.
    idling = 1'b0;
    while (stim_count < StimTarget) build_random_event();
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d byte and end requests in %0d events, plus %0d ignored requests.",
             stim_count, end_count, noise_count);
    $display("Checked %0d verdicts; rules seen firing (rule 7 first): %b", checked,
             rules_seen);
    if (errors == 0) begin
      $display("event_signature_matcher_tb passed");
    end else begin
      $display("event_signature_matcher_tb failed");
    end
    $finish;
  end

endmodule
